// ===== src/source_text_tokenizer_defines.svh =====
// assertion macros for the source text tokenizer checker
// no dependencies; expects clk_i and rst_ni in the including scope
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// implication checked every clock, off while in reset
`define STT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked every clock, off while in reset
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/stt_pkg.sv =====
// types, token codes and keyword table of the source text tokenizer
// no dependencies
`timescale 1ns / 1ps

package stt_pkg;

  localparam int unsigned KindW = 7;
  localparam int unsigned ErrW  = 3;
  localparam int unsigned LineW = 16;
  localparam int unsigned OffW  = 24;
  localparam int unsigned NumKw = 25;

  localparam logic [KindW-1:0] K_IDENT   = 7'd0;
  localparam logic [KindW-1:0] K_INTEGER = 7'd26;
  localparam logic [KindW-1:0] K_DECIMAL = 7'd27;
  localparam logic [KindW-1:0] K_STRING  = 7'd28;
  localparam logic [KindW-1:0] K_INVALID = 7'd67;
  localparam logic [KindW-1:0] K_EMPTY   = 7'd68;

  localparam logic [ErrW-1:0] E_NONE       = 3'd0;
  localparam logic [ErrW-1:0] E_UNEXPECTED = 3'd1;
  localparam logic [ErrW-1:0] E_OPEN_SQ    = 3'd2;
  localparam logic [ErrW-1:0] E_OPEN_DQ    = 3'd3;
  localparam logic [ErrW-1:0] E_OPEN_CMT   = 3'd4;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  // keyword text, left aligned and padded with spaces
  localparam logic [63:0] KW_TEXT [NumKw] = '{
    "break   ", "char    ", "class   ", "continue", "do      ", "double  ",
    "else    ", "false   ", "for     ", "function", "if      ", "integer ",
    "nil     ", "null    ", "not     ", "print   ", "read    ", "repeat  ",
    "return  ", "string  ", "true    ", "until   ", "var     ", "while   ",
    "write   "
  };
  localparam logic [3:0] KW_LEN [NumKw] = '{
    4'd5, 4'd4, 4'd5, 4'd8, 4'd2, 4'd6, 4'd4, 4'd5, 4'd3, 4'd8, 4'd2, 4'd7, 4'd3,
    4'd4, 4'd3, 4'd5, 4'd4, 4'd6, 4'd6, 4'd6, 4'd4, 4'd5, 4'd3, 4'd5, 4'd5
  };

  typedef enum logic [3:0] {
    ST_IDLE, ST_WORD, ST_NUM, ST_SQ, ST_DQ, ST_OP, ST_LINE_CMT, ST_BLOCK_CMT
  } scan_state_e;

  typedef struct packed {
    logic             ok;
    logic [KindW-1:0] kind;
  } kind_t;

  typedef struct packed {
    logic [KindW-1:0] token_kind;
    logic [ErrW-1:0]  error_kind;
    logic [LineW-1:0] line_number;
    logic [OffW-1:0]  start_offset;
    logic [OffW-1:0]  lexeme_length;
    logic             zero_before;
    logic             zero_after;
    logic             run_done;
    logic             had_error;
  } res_t;

  // results of one input item: one or two
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } group_t;

  function automatic kind_t single_kind(logic [7:0] c);
    kind_t k;
    k.ok = 1'b1;
    unique case (c)
      8'h3B:   k.kind = 7'd29;
      8'h28:   k.kind = 7'd30;
      8'h29:   k.kind = 7'd31;
      8'h5B:   k.kind = 7'd32;
      8'h5D:   k.kind = 7'd33;
      8'h7B:   k.kind = 7'd34;
      8'h7D:   k.kind = 7'd35;
      8'h7E:   k.kind = 7'd59;
      8'h2C:   k.kind = 7'd60;
      default: begin
        k.ok   = 1'b0;
        k.kind = K_INVALID;
      end
    endcase
    return k;
  endfunction

  function automatic kind_t alone_kind(logic [7:0] c);
    kind_t k;
    k.ok = 1'b1;
    unique case (c)
      8'h2E:   k.kind = 7'd36;
      8'h2B:   k.kind = 7'd37;
      8'h2D:   k.kind = 7'd40;
      8'h2A:   k.kind = 7'd43;
      8'h2F:   k.kind = 7'd45;
      8'h3D:   k.kind = 7'd47;
      8'h21:   k.kind = 7'd49;
      8'h26:   k.kind = 7'd51;
      8'h7C:   k.kind = 7'd54;
      8'h5E:   k.kind = 7'd57;
      8'h3E:   k.kind = 7'd61;
      8'h3C:   k.kind = 7'd63;
      8'h25:   k.kind = 7'd65;
      default: begin
        k.ok   = 1'b0;
        k.kind = 7'd45;
      end
    endcase
    return k;
  endfunction

  function automatic kind_t pair_kind(logic [7:0] p, logic [7:0] c);
    kind_t k;
    k.ok   = 1'b0;
    k.kind = K_INVALID;
    if (c == CH_EQ) begin
      k.ok = 1'b1;
      unique case (p)
        8'h2B:   k.kind = 7'd38;
        8'h2D:   k.kind = 7'd41;
        8'h2A:   k.kind = 7'd44;
        8'h2F:   k.kind = 7'd46;
        8'h3D:   k.kind = 7'd48;
        8'h21:   k.kind = 7'd50;
        8'h26:   k.kind = 7'd52;
        8'h7C:   k.kind = 7'd55;
        8'h5E:   k.kind = 7'd58;
        8'h3E:   k.kind = 7'd62;
        8'h3C:   k.kind = 7'd64;
        8'h25:   k.kind = 7'd66;
        default: k.ok = 1'b0;
      endcase
    end else if (c == p) begin
      k.ok = 1'b1;
      unique case (p)
        8'h2B:   k.kind = 7'd39;
        8'h2D:   k.kind = 7'd42;
        8'h26:   k.kind = 7'd53;
        8'h7C:   k.kind = 7'd56;
        default: k.ok = 1'b0;
      endcase
    end
    return k;
  endfunction

endpackage

// ===== src/stt_if.sv =====
// valid/ready channel interfaces of the source text tokenizer
// depends on stt_pkg
`timescale 1ns / 1ps

interface stt_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] char_byte;

  modport source (output valid, mode, char_byte, input ready);
  modport sink (input valid, mode, char_byte, output ready);
endinterface

interface stt_out_if;
  logic                            valid;
  logic                            ready;
  logic [stt_pkg::KindW-1:0]       token_kind;
  logic [stt_pkg::ErrW-1:0]        error_kind;
  logic [stt_pkg::LineW-1:0]       line_number;
  logic [stt_pkg::OffW-1:0]        start_offset;
  logic [stt_pkg::OffW-1:0]        lexeme_length;
  logic                            zero_before;
  logic                            zero_after;
  logic                            run_done;
  logic                            had_error;
  logic                            last;

  modport source (output valid, token_kind, error_kind, line_number, start_offset,
                  lexeme_length, zero_before, zero_after, run_done, had_error, last,
                  input ready);
  modport sink (input valid, token_kind, error_kind, line_number, start_offset,
                lexeme_length, zero_before, zero_after, run_done, had_error, last,
                output ready);
endinterface

// ===== src/stt_scan.sv =====
// front part: scanner state machine, classifies each byte and builds result groups
// depends on stt_pkg
`timescale 1ns / 1ps

module stt_scan #(
  parameter int unsigned POSITION_BITS   = 24,
  parameter int unsigned LINE_BITS       = 16,
  parameter int unsigned KEYWORD_MAX_LEN = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic            mode_i,
  input  logic [7:0]      char_i,
  output logic            push_o,
  output stt_pkg::group_t group_o
);
  import stt_pkg::*;

  localparam int unsigned PB  = POSITION_BITS;
  localparam int unsigned LB  = LINE_BITS;
  localparam int unsigned IW  = $clog2(KEYWORD_MAX_LEN);
  localparam int unsigned WLW = $clog2(KEYWORD_MAX_LEN + 2);
  localparam logic [PB-1:0]  POS_TOP  = '1;
  localparam logic [LB-1:0]  LINE_TOP = '1;
  localparam logic [WLW-1:0] KW_MAX   = WLW'(KEYWORD_MAX_LEN);

  scan_state_e    st_q, st_d;
  logic [PB-1:0]  pos_q, pos_d, tstart_q, tstart_d, lexlen_q, lexlen_d;
  logic [LB-1:0]  line_q, line_d;
  logic [WLW-1:0] wlen_q, wlen_d;
  logic           point_q, point_d, lead_q, lead_d, trail_q, trail_d;
  logic           star_q, star_d, err_q, err_d;
  logic [7:0]     pend_q, pend_d;
  logic [7:0]     wbuf_q [KEYWORD_MAX_LEN];
  logic           wr_en;
  logic [IW-1:0]  wr_idx;

  logic c_alpha, c_digit, c_nl, c_quote_sq, c_quote_dq;
  kind_t pk, ak_p, ak_c, sk;
  logic taken, byte_i;
  logic [PB-1:0] lexlen_inc, tstart_inc;
  logic [KindW-1:0] word_kind;

  function automatic logic [OffW-1:0] to_off(logic [PB-1:0] v);
    logic [47:0] w;
    w = 48'(v);
    return w[OffW-1:0];
  endfunction

  function automatic res_t mk(logic [KindW-1:0] k, logic [ErrW-1:0] e, logic [LB-1:0] ln,
                              logic [PB-1:0] s, logic [PB-1:0] l, logic zb, logic za);
    res_t r;
    logic [31:0] lw;
    lw = 32'(ln);
    r.token_kind    = k;
    r.error_kind    = e;
    r.line_number   = lw[LineW-1:0];
    r.start_offset  = to_off(s);
    r.lexeme_length = to_off(l);
    r.zero_before   = zb;
    r.zero_after    = za;
    r.run_done      = 1'b0;
    r.had_error     = 1'b0;
    return r;
  endfunction

  assign byte_i     = accept_i && !mode_i;
  assign c_alpha    = (char_i >= 8'h61 && char_i <= 8'h7A) ||
                      (char_i >= 8'h41 && char_i <= 8'h5A) || char_i == CH_UNDER;
  assign c_digit    = char_i >= 8'h30 && char_i <= 8'h39;
  assign c_nl       = char_i == CH_NL;
  assign c_quote_sq = char_i == CH_SQ;
  assign c_quote_dq = char_i == CH_DQ;
  assign pk         = pair_kind(pend_q, char_i);
  assign ak_p       = alone_kind(pend_q);
  assign ak_c       = alone_kind(char_i);
  assign sk         = single_kind(char_i);
  assign lexlen_inc = (lexlen_q == POS_TOP) ? lexlen_q : lexlen_q + 1'b1;
  assign tstart_inc = (tstart_q == POS_TOP) ? tstart_q : tstart_q + 1'b1;

  // keyword lookup over the word buffer
  always_comb begin
    logic hit;
    word_kind = K_IDENT;
    for (int i = 0; i < NumKw; i++) begin
      hit = (wlen_q == WLW'(KW_LEN[i]));
      for (int j = 0; j < 8; j++) begin
        if (j < KW_LEN[i] && wbuf_q[j] != KW_TEXT[i][8*(7-j) +: 8]) hit = 1'b0;
      end
      if (hit) word_kind = KindW'(i + 1);
    end
  end

  // does the open token take this byte
  always_comb begin
    unique case (st_q)
      ST_WORD:      taken = c_alpha || c_digit;
      ST_NUM:       taken = c_digit || (char_i == CH_DOT && !point_q);
      ST_SQ, ST_DQ: taken = !c_nl;
      ST_LINE_CMT:  taken = !c_nl;
      ST_BLOCK_CMT: taken = 1'b1;
      ST_OP:        taken = (pend_q == CH_DOT && c_digit) ||
                            (pend_q == CH_SLASH && (char_i == CH_SLASH || char_i == CH_STAR)) ||
                            pk.ok;
      default:      taken = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    st_d = st_q; pos_d = pos_q; line_d = line_q; tstart_d = tstart_q; lexlen_d = lexlen_q;
    wlen_d = wlen_q; point_d = point_q; lead_d = lead_q; trail_d = trail_q;
    star_d = star_q; err_d = err_q; pend_d = pend_q;
    wr_en = 1'b0; wr_idx = '0;
    if (accept_i && mode_i) begin
      if (st_q == ST_SQ || st_q == ST_DQ || st_q == ST_BLOCK_CMT) err_d = 1'b1;
      st_d = ST_IDLE;
    end else if (byte_i) begin
      pos_d = (pos_q == POS_TOP) ? pos_q : pos_q + 1'b1;
      if (taken) begin
        unique case (st_q)
          ST_WORD: begin
            if (wlen_q < KW_MAX) begin
              wr_en  = 1'b1;
              wr_idx = wlen_q[IW-1:0];
            end
            if (wlen_q <= KW_MAX) wlen_d = wlen_q + 1'b1;
            lexlen_d = lexlen_inc;
          end
          ST_NUM: begin
            lexlen_d = lexlen_inc;
            if (c_digit) trail_d = 1'b0;
            else begin
              point_d = 1'b1;
              trail_d = 1'b1;
            end
          end
          ST_SQ, ST_DQ: begin
            if ((st_q == ST_SQ && c_quote_sq) || (st_q == ST_DQ && c_quote_dq)) st_d = ST_IDLE;
            else lexlen_d = lexlen_inc;
          end
          ST_BLOCK_CMT: begin
            if (c_nl) line_d = (line_q == LINE_TOP) ? line_q : line_q + 1'b1;
            if (star_q && char_i == CH_SLASH) st_d = ST_IDLE;
            star_d = (char_i == CH_STAR);
          end
          ST_OP: begin
            if (pend_q == CH_DOT && c_digit) begin
              st_d = ST_NUM; point_d = 1'b1; lead_d = 1'b1; trail_d = 1'b0;
              lexlen_d = PB'(2);
            end else if (pend_q == CH_SLASH && char_i == CH_SLASH) begin
              st_d = ST_LINE_CMT;
            end else if (pend_q == CH_SLASH && char_i == CH_STAR) begin
              st_d = ST_BLOCK_CMT; star_d = 1'b0;
            end else begin
              st_d = ST_IDLE;
            end
          end
          default: ;
        endcase
      end else begin
        if ((st_q == ST_SQ || st_q == ST_DQ) && c_nl) err_d = 1'b1;
        st_d = ST_IDLE;
        if (char_i == CH_SPACE || char_i == CH_TAB) begin
        end else if (c_nl) begin
          line_d = (line_q == LINE_TOP) ? line_q : line_q + 1'b1;
        end else if (c_alpha || c_digit || c_quote_sq || c_quote_dq || char_i == CH_HASH ||
                     (!sk.ok && ak_c.ok)) begin
          tstart_d = pos_q;
          lexlen_d = PB'(1);
          if (c_alpha) begin
            st_d = ST_WORD; wlen_d = WLW'(1); wr_en = 1'b1;
          end else if (c_digit) begin
            st_d = ST_NUM; point_d = 1'b0; lead_d = 1'b0; trail_d = 1'b0;
          end else if (c_quote_sq || c_quote_dq) begin
            lexlen_d = '0;
            st_d = c_quote_sq ? ST_SQ : ST_DQ;
          end else if (char_i == CH_HASH) begin
            st_d = ST_LINE_CMT;
          end else begin
            st_d = ST_OP; pend_d = char_i;
          end
        end else if (!sk.ok) begin
          err_d = 1'b1;
        end
      end
    end
  end

  // result group for this item
  always_comb begin
    res_t cont_r, start_r, flush_r, stat_r;
    logic cont_v, start_v, flush_v;
    cont_v = 1'b0; start_v = 1'b0; flush_v = 1'b0;
    cont_r = mk(word_kind, E_NONE, line_q, tstart_q, lexlen_q, 1'b0, 1'b0);
    unique case (st_q)
      ST_WORD: cont_v = !taken;
      ST_NUM: begin
        cont_v = !taken;
        cont_r = mk(point_q ? K_DECIMAL : K_INTEGER, E_NONE, line_q, tstart_q, lexlen_q,
                     lead_q, trail_q);
      end
      ST_SQ, ST_DQ: begin
        if (c_nl) begin
          cont_v = 1'b1;
          cont_r = mk(K_INVALID, (st_q == ST_SQ) ? E_OPEN_SQ : E_OPEN_DQ, line_q, tstart_q,
                      lexlen_inc, 1'b0, 1'b0);
        end else if ((st_q == ST_SQ && c_quote_sq) || (st_q == ST_DQ && c_quote_dq)) begin
          cont_v = 1'b1;
          cont_r = mk(K_STRING, E_NONE, line_q, tstart_inc, lexlen_q, 1'b0, 1'b0);
        end
      end
      ST_LINE_CMT: begin
        cont_v = c_nl;
        cont_r = mk(K_EMPTY, E_NONE, line_q, tstart_q, '0, 1'b0, 1'b0);
      end
      ST_BLOCK_CMT: begin
        cont_v = star_q && char_i == CH_SLASH;
        cont_r = mk(K_EMPTY, E_NONE, line_q, tstart_q, '0, 1'b0, 1'b0);
      end
      ST_OP: begin
        cont_v = pk.ok || !taken;
        cont_r = pk.ok ? mk(pk.kind, E_NONE, line_q, tstart_q, PB'(2), 1'b0, 1'b0)
                       : mk(ak_p.kind, E_NONE, line_q, tstart_q, PB'(1), 1'b0, 1'b0);
      end
      default: ;
    endcase

    start_v = !taken && !c_nl && char_i != CH_SPACE && char_i != CH_TAB &&
              (sk.ok || !(c_alpha || c_digit || c_quote_sq || c_quote_dq ||
                          char_i == CH_HASH || ak_c.ok));
    start_r = sk.ok ? mk(sk.kind, E_NONE, line_q, pos_q, PB'(1), 1'b0, 1'b0)
                    : mk(K_INVALID, E_UNEXPECTED, line_q, pos_q, PB'(1), 1'b0, 1'b0);

    // flush of a pending token at end of input
    flush_r = cont_r;
    unique case (st_q)
      ST_WORD, ST_NUM: flush_v = 1'b1;
      ST_SQ, ST_DQ: begin
        flush_v = 1'b1;
        flush_r = mk(K_INVALID, (st_q == ST_SQ) ? E_OPEN_SQ : E_OPEN_DQ, line_q, tstart_q,
                     lexlen_inc, 1'b0, 1'b0);
      end
      ST_LINE_CMT: begin
        flush_v = 1'b1;
        flush_r = mk(K_EMPTY, E_NONE, line_q, tstart_q, '0, 1'b0, 1'b0);
      end
      ST_BLOCK_CMT: begin
        flush_v = 1'b1;
        flush_r = mk(K_INVALID, E_OPEN_CMT, line_q, tstart_q, '0, 1'b0, 1'b0);
      end
      ST_OP: begin
        flush_v = 1'b1;
        flush_r = mk(ak_p.kind, E_NONE, line_q, tstart_q, PB'(1), 1'b0, 1'b0);
      end
      default: ;
    endcase
    stat_r           = '0;
    stat_r.run_done  = 1'b1;
    stat_r.had_error = err_d;

    group_o = '0;
    push_o  = 1'b0;
    if (accept_i && mode_i) begin
      push_o      = 1'b1;
      group_o.two = flush_v;
      group_o.r0  = flush_v ? flush_r : stat_r;
      group_o.r1  = stat_r;
    end else if (byte_i) begin
      push_o      = cont_v || start_v;
      group_o.two = cont_v && start_v;
      group_o.r0  = cont_v ? cont_r : start_r;
      group_o.r1  = start_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; pos_q <= '0; line_q <= LB'(1); tstart_q <= '0; lexlen_q <= '0;
      wlen_q <= '0; point_q <= 1'b0; lead_q <= 1'b0; trail_q <= 1'b0; star_q <= 1'b0;
      err_q <= 1'b0; pend_q <= '0;
    end else begin
      st_q <= st_d; pos_q <= pos_d; line_q <= line_d; tstart_q <= tstart_d;
      lexlen_q <= lexlen_d; wlen_q <= wlen_d; point_q <= point_d; lead_q <= lead_d;
      trail_q <= trail_d; star_q <= star_d; err_q <= err_d; pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) wbuf_q[wr_idx] <= char_i;
  end

endmodule

// ===== src/stt_fifo.sv =====
// short queue of result groups between scanner and output stage
// depends on stt_pkg
`timescale 1ns / 1ps

module stt_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  stt_pkg::group_t data_i,
  input  logic            pop_i,
  output stt_pkg::group_t data_o,
  output logic            full_o,
  output logic            empty_o
);
  import stt_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  group_t        mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// ===== src/stt_emit.sv =====
// back part: output register, sends the one or two items of each group
// depends on stt_pkg
`timescale 1ns / 1ps

module stt_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  stt_pkg::group_t group_i,
  output logic            pop_o,
  output logic            valid_o,
  input  logic            ready_i,
  output stt_pkg::res_t   res_o,
  output logic            last_o
);
  import stt_pkg::*;

  group_t cur_q;
  logic   valid_q, sel_q;
  logic   done;

  assign done    = valid_q && ready_i && (sel_q || !cur_q.two);
  assign pop_o   = !empty_i && (!valid_q || done);
  assign valid_o = valid_q;
  assign res_o   = sel_q ? cur_q.r1 : cur_q.r0;
  assign last_o  = sel_q || !cur_q.two;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0; sel_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1; sel_q <= 1'b0;
    end else if (done) begin
      valid_q <= 1'b0; sel_q <= 1'b0;
    end else if (valid_q && ready_i) begin
      sel_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= group_i;
  end

endmodule

// ===== src/source_text_tokenizer.sv =====
// top level of the source text tokenizer: scanner, group queue, output stage
// depends on stt_pkg, stt_if, stt_scan, stt_fifo, stt_emit
`timescale 1ns / 1ps

// Streaming tokenizer: one source byte (mode 0) or an end marker (mode 1) per input
// item, and one byte is taken every clock while the four-entry group queue has room.
// Each byte yields zero, one or two tokens, and the end marker yields any pending token
// followed by a status item with run_done and had_error. Tokens leave through an output
// register at one item per clock while the receiver is ready, so a run of bytes that
// each close one token and open another drains at half rate and fills the queue; input
// ready then drops until the output stage catches up. Tokens pass the group queue and
// then the output register. Offsets and line numbers saturate at the widths set by
// POSITION_BITS and LINE_BITS and are shown in the low bits of the output fields.
module source_text_tokenizer #(
  parameter int unsigned POSITION_BITS   = 24,
  parameter int unsigned LINE_BITS       = 16,
  parameter int unsigned KEYWORD_MAX_LEN = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_in_if.sink    in_i,
  stt_out_if.source out_o
);
  import stt_pkg::*;

  logic   accept, push, pop, full, empty, last;
  group_t grp_in, grp_out;
  res_t   res;

  // byte taken whenever the queue can hold the worst case group
  assign in_i.ready = !full;
  assign accept     = in_i.valid && !full;

  // front: scanner state and token classification
  stt_scan #(
    .POSITION_BITS  (POSITION_BITS),
    .LINE_BITS      (LINE_BITS),
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .mode_i  (in_i.mode),
    .char_i  (in_i.char_byte),
    .push_o  (push),
    .group_o (grp_in)
  );

  // queue that lets scanner and output stall independently
  stt_fifo #(.DEPTH(4)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (grp_in),
    .pop_i  (pop),
    .data_o (grp_out),
    .full_o (full),
    .empty_o(empty)
  );

  // back: output register and serializing of two-token groups
  stt_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(empty),
    .group_i(grp_out),
    .pop_o  (pop),
    .valid_o(out_o.valid),
    .ready_i(out_o.ready),
    .res_o  (res),
    .last_o (last)
  );

  assign out_o.token_kind    = res.token_kind;
  assign out_o.error_kind    = res.error_kind;
  assign out_o.line_number   = res.line_number;
  assign out_o.start_offset  = res.start_offset;
  assign out_o.lexeme_length = res.lexeme_length;
  assign out_o.zero_before   = res.zero_before;
  assign out_o.zero_after    = res.zero_after;
  assign out_o.run_done      = res.run_done;
  assign out_o.had_error     = res.had_error;
  assign out_o.last          = last;

endmodule

// ===== src/stt_checker.sv =====
// port-level checks of the source text tokenizer, bound to the top level
// depends on stt_pkg and source_text_tokenizer_defines.svh
`timescale 1ns / 1ps
`include "source_text_tokenizer_defines.svh"

module stt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [stt_pkg::KindW-1:0] token_kind_i,
  input logic [stt_pkg::OffW-1:0]  start_offset_i,
  input logic                      run_done_i,
  input logic                      had_error_i,
  input logic                      last_i
);
  import stt_pkg::*;

  `STT_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(token_kind_i) && $stable(start_offset_i) && $stable(last_i), "output item changed while stalled")
  `STT_ASSERT_IMP(a_status_last, out_valid_i && run_done_i, last_i && token_kind_i == K_IDENT, "status item not last or not clear")
  `STT_ASSERT_IMP(a_err_only_status, out_valid_i && !run_done_i, !had_error_i, "error flag on a token item")

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .token_kind_i  (out_o.token_kind),
  .start_offset_i(out_o.start_offset),
  .run_done_i    (out_o.run_done),
  .had_error_i   (out_o.had_error),
  .last_i        (out_o.last)
);

// ===== bench/stt_token_checker.sv =====
// token checker for the source text tokenizer: predicts the tokens of every accepted
// item and compares each delivered token with the oldest prediction
// depends on stt_pkg and the stt_in_if / stt_out_if channels
`timescale 1ns / 1ps

module stt_token_checker (
  input  logic clk_i,
  input  logic rst_ni,
  stt_in_if    in_m,
  stt_out_if   out_m,
  output int   fail_o,
  output int   pending_o,
  output int   tokens_o
);
  import stt_pkg::*;

  localparam logic [KindW-1:0] KIND_DOT   = 7'd36;
  localparam logic [KindW-1:0] KIND_SLASH = 7'd45;
  localparam logic [OffW-1:0]  OFF_TOP    = '1;
  localparam logic [LineW-1:0] LINE_TOP   = '1;

  typedef struct {
    res_t r;
    logic last;
  } token_exp_t;

  token_exp_t token_q [$];

  scan_state_e      lex_state;
  logic [OffW-1:0]  byte_pos;
  logic [LineW-1:0] line_cnt;
  logic [OffW-1:0]  tok_start;
  logic [7:0]       word_buf [8];
  int               word_len;
  logic             point_seen;
  logic [7:0]       pend_op;
  logic             err_seen;
  logic [OffW-1:0]  lex_len;
  logic             lead_point;
  logic             trail_point;
  logic             star_seen;
  int               fails;
  int               tokens;

  assign fail_o    = fails;
  assign pending_o = token_q.size();
  assign tokens_o  = tokens;

  function automatic logic [OffW-1:0] sat_off(logic [OffW-1:0] v);
    return (v == OFF_TOP) ? v : v + 1'b1;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int lone_kind(logic [7:0] c);
    case (c)
      ";": return 29;  "(": return 30;  ")": return 31;
      "[": return 32;  "]": return 33;  "{": return 34;
      "}": return 35;  "~": return 59;  ",": return 60;
      default: return -1;
    endcase
  endfunction

  // operators that wait for a possible second character
  function automatic int held_kind(logic [7:0] c);
    case (c)
      ".": return 36;  "+": return 37;  "-": return 40;  "*": return 43;
      "/": return 45;  "=": return 47;  "!": return 49;  "&": return 51;
      "|": return 54;  "^": return 57;  ">": return 61;  "<": return 63;
      "%": return 65;
      default: return -1;
    endcase
  endfunction

  function automatic int twin_kind(logic [7:0] p, logic [7:0] c);
    if (c == CH_EQ) begin
      case (p)
        "+": return 38;  "-": return 41;  "*": return 44;  "/": return 46;
        "=": return 48;  "!": return 50;  "&": return 52;  "|": return 55;
        "^": return 58;  ">": return 62;  "<": return 64;  "%": return 66;
        default: return -1;
      endcase
    end
    if (c == p) begin
      case (p)
        "+": return 39;  "-": return 42;  "&": return 53;  "|": return 56;
        default: return -1;
      endcase
    end
    return -1;
  endfunction

  function automatic logic [KindW-1:0] keyword_kind();
    logic hit;
    if (word_len > 8) return K_IDENT;
    for (int i = 0; i < NumKw; i++) begin
      if (KW_LEN[i] == word_len) begin
        hit = 1'b1;
        for (int j = 0; j < word_len; j++)
          if (word_buf[j] != KW_TEXT[i][63-8*j -: 8]) hit = 1'b0;
        if (hit) return KindW'(i + 1);
      end
    end
    return K_IDENT;
  endfunction

  task automatic push_token(logic [KindW-1:0] kind, logic [ErrW-1:0] err,
                            logic [OffW-1:0] start, logic [OffW-1:0] len,
                            logic zb, logic za);
    token_exp_t t;
    t.r = '0;
    t.r.token_kind    = kind;
    t.r.error_kind    = err;
    t.r.line_number   = line_cnt;
    t.r.start_offset  = start;
    t.r.lexeme_length = len;
    t.r.zero_before   = zb;
    t.r.zero_after    = za;
    t.last = 1'b0;
    token_q = {token_q, t};
  endtask

  task automatic push_number();
    push_token(point_seen ? K_DECIMAL : K_INTEGER, E_NONE, tok_start, lex_len,
               lead_point, trail_point);
  endtask

  task automatic push_open_string();
    err_seen = 1'b1;
    push_token(K_INVALID, (lex_state == ST_SQ) ? E_OPEN_SQ : E_OPEN_DQ, tok_start,
               sat_off(lex_len), 1'b0, 1'b0);
  endtask

  // first character of a new token, or a separator
  task automatic open_token(logic [7:0] c, logic [OffW-1:0] pos);
    lex_state = ST_IDLE;
    if (c == CH_SPACE || c == CH_TAB) return;
    if (c == CH_NL) begin
      line_cnt = (line_cnt == LINE_TOP) ? line_cnt : line_cnt + 1'b1;
      return;
    end
    tok_start = pos;
    lex_len   = OffW'(1);
    if (is_letter(c)) begin
      lex_state   = ST_WORD;
      word_buf[0] = c;
      word_len    = 1;
    end else if (is_num(c)) begin
      lex_state   = ST_NUM;
      point_seen  = 1'b0;
      lead_point  = 1'b0;
      trail_point = 1'b0;
    end else if (c == CH_SQ || c == CH_DQ) begin
      lex_len   = '0;
      lex_state = (c == CH_SQ) ? ST_SQ : ST_DQ;
    end else if (c == CH_HASH) begin
      lex_state = ST_LINE_CMT;
    end else if (lone_kind(c) >= 0) begin
      push_token(KindW'(lone_kind(c)), E_NONE, pos, OffW'(1), 1'b0, 1'b0);
    end else if (held_kind(c) >= 0) begin
      pend_op   = c;
      lex_state = ST_OP;
    end else begin
      err_seen = 1'b1;
      push_token(K_INVALID, E_UNEXPECTED, pos, OffW'(1), 1'b0, 1'b0);
    end
  endtask

  // returns 1 when the running token takes the character
  task automatic extend_token(input logic [7:0] c, output logic taken);
    int k;
    taken = 1'b0;
    case (lex_state)
      ST_WORD: begin
        if (is_letter(c) || is_num(c)) begin
          if (word_len < 8) word_buf[word_len] = c;
          if (word_len <= 8) word_len++;
          lex_len = sat_off(lex_len);
          taken = 1'b1;
        end else begin
          push_token(keyword_kind(), E_NONE, tok_start, lex_len, 1'b0, 1'b0);
        end
      end
      ST_NUM: begin
        if (is_num(c)) begin
          trail_point = 1'b0;
          lex_len = sat_off(lex_len);
          taken = 1'b1;
        end else if (c == CH_DOT && !point_seen) begin
          point_seen  = 1'b1;
          trail_point = 1'b1;
          lex_len = sat_off(lex_len);
          taken = 1'b1;
        end else begin
          push_number();
        end
      end
      ST_SQ, ST_DQ: begin
        if (c == ((lex_state == ST_SQ) ? CH_SQ : CH_DQ)) begin
          push_token(K_STRING, E_NONE, sat_off(tok_start), lex_len, 1'b0, 1'b0);
          lex_state = ST_IDLE;
          taken = 1'b1;
        end else if (c == CH_NL) begin
          push_open_string();
        end else begin
          lex_len = sat_off(lex_len);
          taken = 1'b1;
        end
      end
      ST_LINE_CMT: begin
        if (c == CH_NL) push_token(K_EMPTY, E_NONE, tok_start, '0, 1'b0, 1'b0);
        else taken = 1'b1;
      end
      ST_BLOCK_CMT: begin
        if (c == CH_NL) line_cnt = (line_cnt == LINE_TOP) ? line_cnt : line_cnt + 1'b1;
        taken = 1'b1;
        if (star_seen && c == CH_SLASH) begin
          push_token(K_EMPTY, E_NONE, tok_start, '0, 1'b0, 1'b0);
          lex_state = ST_IDLE;
        end else begin
          star_seen = (c == CH_STAR);
        end
      end
      ST_OP: begin
        taken = 1'b1;
        if (pend_op == CH_DOT && is_num(c)) begin
          lex_state   = ST_NUM;
          point_seen  = 1'b1;
          lead_point  = 1'b1;
          trail_point = 1'b0;
          lex_len     = OffW'(2);
        end else if (pend_op == CH_SLASH && c == CH_SLASH) begin
          lex_state = ST_LINE_CMT;
        end else if (pend_op == CH_SLASH && c == CH_STAR) begin
          lex_state = ST_BLOCK_CMT;
          star_seen = 1'b0;
        end else if (twin_kind(pend_op, c) >= 0) begin
          push_token(KindW'(twin_kind(pend_op, c)), E_NONE, tok_start, OffW'(2), 1'b0,
                     1'b0);
          lex_state = ST_IDLE;
        end else begin
          k = held_kind(pend_op);
          push_token(k >= 0 ? KindW'(k) : KIND_SLASH, E_NONE, tok_start, OffW'(1), 1'b0,
                     1'b0);
          taken = 1'b0;
        end
      end
      default: taken = 1'b0;
    endcase
  endtask

  // end marker: close the running token, then the status item
  task automatic close_run();
    token_exp_t t;
    int k;
    case (lex_state)
      ST_WORD:  push_token(keyword_kind(), E_NONE, tok_start, lex_len, 1'b0, 1'b0);
      ST_NUM:   push_number();
      ST_SQ, ST_DQ: push_open_string();
      ST_LINE_CMT: push_token(K_EMPTY, E_NONE, tok_start, '0, 1'b0, 1'b0);
      ST_BLOCK_CMT: begin
        err_seen = 1'b1;
        push_token(K_INVALID, E_OPEN_CMT, tok_start, '0, 1'b0, 1'b0);
      end
      ST_OP: begin
        k = held_kind(pend_op);
        push_token(k >= 0 ? KindW'(k) : KIND_DOT, E_NONE, tok_start, OffW'(1), 1'b0, 1'b0);
      end
      default: ;
    endcase
    lex_state = ST_IDLE;
    t.r = '0;
    t.r.run_done  = 1'b1;
    t.r.had_error = err_seen;
    t.last = 1'b0;
    token_q = {token_q, t};
  endtask

  task automatic scan_item(logic mode, logic [7:0] c);
    int prev_size;
    logic taken;
    logic [OffW-1:0] pos;
    prev_size = token_q.size();
    if (mode) begin
      close_run();
    end else begin
      pos = byte_pos;
      byte_pos = sat_off(byte_pos);
      extend_token(c, taken);
      if (!taken) open_token(c, pos);
    end
    if (token_q.size() > prev_size) token_q[$].last = 1'b1;
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t ns token %0d: %s is %0d, wanted %0d", $time, tokens, field, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    token_exp_t w;
    if (!rst_ni) begin
      token_q.delete();
      lex_state   = ST_IDLE;
      byte_pos    = '0;
      line_cnt    = LineW'(1);
      tok_start   = '0;
      word_len    = 0;
      point_seen  = 1'b0;
      pend_op     = '0;
      err_seen    = 1'b0;
      lex_len     = '0;
      lead_point  = 1'b0;
      trail_point = 1'b0;
      star_seen   = 1'b0;
      fails       = 0;
      tokens      = 0;
    end else begin
      if (out_m.valid && out_m.ready) begin
        if (token_q.size() == 0) begin
          report_mismatch("token with nothing predicted, kind", out_m.token_kind, -1);
        end else begin
          w = token_q.pop_front();
          if (out_m.token_kind != w.r.token_kind)
            report_mismatch("token_kind", out_m.token_kind, w.r.token_kind);
          if (out_m.error_kind != w.r.error_kind)
            report_mismatch("error_kind", out_m.error_kind, w.r.error_kind);
          if (out_m.line_number != w.r.line_number)
            report_mismatch("line_number", out_m.line_number, w.r.line_number);
          if (out_m.start_offset != w.r.start_offset)
            report_mismatch("start_offset", out_m.start_offset, w.r.start_offset);
          if (out_m.lexeme_length != w.r.lexeme_length)
            report_mismatch("lexeme_length", out_m.lexeme_length, w.r.lexeme_length);
          if (out_m.zero_before != w.r.zero_before)
            report_mismatch("zero_before", out_m.zero_before, w.r.zero_before);
          if (out_m.zero_after != w.r.zero_after)
            report_mismatch("zero_after", out_m.zero_after, w.r.zero_after);
          if (out_m.run_done != w.r.run_done)
            report_mismatch("run_done", out_m.run_done, w.r.run_done);
          if (out_m.had_error != w.r.had_error)
            report_mismatch("had_error", out_m.had_error, w.r.had_error);
          if (out_m.last != w.last)
            report_mismatch("last", out_m.last, w.last);
        end
        tokens++;
      end
      if (in_m.valid && in_m.ready) scan_item(in_m.mode, in_m.char_byte);
    end
  end

endmodule

// ===== bench/source_text_tokenizer_test.sv =====
// top of the source text tokenizer regression: clock, reset, source text stimulus,
// receiver back-pressure and the verdict
// depends on stt_pkg, stt_if, source_text_tokenizer and stt_token_checker
`timescale 1ns / 1ps

module source_text_tokenizer_test;
  import stt_pkg::*;

  localparam int PHASE_ITEMS = 235;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  stt_in_if  in_ch ();
  stt_out_if out_ch ();

  int fail_cnt;
  int pending_cnt;
  int token_cnt;
  int sent_cnt = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // fragment of source text waiting to be sent, one byte per item
  logic [7:0] text_q [$];

  always #6 clk_i = ~clk_i;

  source_text_tokenizer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  stt_token_checker checker_u (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_m      (in_ch),
    .out_m     (out_ch),
    .fail_o    (fail_cnt),
    .pending_o (pending_cnt),
    .tokens_o  (token_cnt)
  );

  // receiver: random stalls, plus one long hold-off early in the second phase so the
  // group queue fills and the tokenizer has to drop its input ready
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready = 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else if (!hold_done && sent_cnt >= 300) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = ($urandom_range(0, 99) < rcv_idle) ? 1'b0 : 1'b1;
    end
  end

  // one item; inputs change only at the falling edge, acceptance seen at the rising edge
  task automatic send_item(logic mode, logic [7:0] c);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     = 1'b1;
    in_ch.mode      = mode;
    in_ch.char_byte = c;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic send_text();
    while (text_q.size() > 0) send_item(1'b0, text_q.pop_front());
  endtask

  task automatic queue_byte(logic [7:0] c);
    text_q = {text_q, c};
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // printable byte other than the given quote, and now and then a newline
  function automatic logic [7:0] body_char(logic [7:0] quote);
    logic [7:0] c;
    if ($urandom_range(0, 19) == 0) return CH_NL;
    c = 8'($urandom_range(32, 126));
    return (c == quote) ? "x" : c;
  endfunction

  // one random lexeme, mostly well formed, with noise mixed in
  task automatic add_fragment();
    int n;
    int k;
    logic [7:0] q;
    case ($urandom_range(0, 12))
      0, 1: begin
        k = $urandom_range(0, NumKw - 1);
        for (int j = 0; j < KW_LEN[k]; j++) queue_byte(KW_TEXT[k][63-8*j -: 8]);
        // keyword with a tail turns into an identifier
        if ($urandom_range(0, 4) == 0) queue_byte(pick("_a9Z"));
      end
      2: begin
        queue_byte(pick("abcdefghijklmnopqrstuvwxyzABCXYZ_"));
        n = $urandom_range(0, 11);
        repeat (n) queue_byte(pick("abcdefghijklmnopqrstuvwxyzQ_0123456789"));
      end
      3: begin
        n = $urandom_range(1, 5);
        repeat (n) queue_byte(pick("0123456789"));
      end
      4: begin
        // decimals: .5 7. 12.25 and a second point
        case ($urandom_range(0, 3))
          0: add_text(".5");
          1: add_text("7.");
          2: add_text("12.25");
          default: add_text("3.1.4");
        endcase
      end
      5: begin
        q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
        queue_byte(q);
        n = $urandom_range(0, 6);
        repeat (n) queue_byte(body_char(q));
        if ($urandom_range(0, 9) != 0) queue_byte(q);
      end
      6, 7: begin
        queue_byte(pick("+-*/=!&|^<>%.;()[]{}~,"));
        if ($urandom_range(0, 1)) queue_byte(pick("==+-&|<>."));
      end
      8: begin
        if ($urandom_range(0, 1)) add_text("//");
        else queue_byte(CH_HASH);
        n = $urandom_range(0, 5);
        repeat (n) queue_byte(body_char(CH_NL));
        queue_byte(CH_NL);
      end
      9: begin
        add_text("/*");
        n = $urandom_range(0, 6);
        repeat (n) queue_byte(pick("ab*/\n "));
        if ($urandom_range(0, 9) != 0) add_text("*/");
      end
      10: queue_byte(pick(" \t\n"));
      default: queue_byte(8'($urandom_range(0, 255)));
    endcase
    // a separator most of the time, otherwise lexemes run into each other
    if ($urandom_range(0, 9) < 6) queue_byte(pick("  \t\n"));
  endtask

  task automatic wait_drained();
    while (pending_cnt != 0) @(posedge clk_i);
    // a byte that closes nothing may still be inside the scanner
    repeat (6) @(posedge clk_i);
  endtask

  task automatic run_phase(int items);
    int start;
    start = sent_cnt;
    while (sent_cnt - start < items) begin
      add_fragment();
      send_text();
      if ($urandom_range(0, 39) == 0) send_item(1'b1, 8'($urandom_range(0, 255)));
    end
    send_item(1'b1, 8'($urandom_range(0, 255)));
    in_ch.valid = 1'b0;
    wait_drained();
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.mode      = 1'b0;
    in_ch.char_byte = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    snd_idle = 24;
    rcv_idle = 71;
    // directed: keyword, below-or-equal, point forms, both comment kinds, a block
    // comment slash-star-slash-star-slash that closes, newline right after a quote and an
    // unterminated double quote flushed by the end marker
    add_text("if<=x\n.5 1.//c\n/*/*/'\n\"");
    send_text();
    send_item(1'b1, 8'hFF);
    in_ch.valid = 1'b0;
    wait_drained();

    run_phase(PHASE_ITEMS);
    snd_idle = 71;
    rcv_idle = 24;
    run_phase(PHASE_ITEMS);
    snd_idle = 0;
    rcv_idle = 0;
    run_phase(PHASE_ITEMS);

    $display("covered %0d source items and %0d tokens under three stall mixes",
             sent_cnt, token_cnt);
    $display("including a long receiver hold-off and drained pauses between runs");
    if (fail_cnt == 0) begin
      $display("source_text_tokenizer regression: pass");
    end else begin
      $display("source_text_tokenizer regression: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20000000;
    $display("source_text_tokenizer regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/stt_pkg.sv
src/stt_if.sv
src/stt_scan.sv
src/stt_fifo.sv
src/stt_emit.sv
src/source_text_tokenizer.sv
src/stt_checker.sv
bench/stt_token_checker.sv
bench/source_text_tokenizer_test.sv
